FILE: design/hex_record_data_extractor_assert.svh
// Assertion macros used by the HEX record extractor RTL.
`ifndef HEX_RECORD_DATA_EXTRACTOR_ASSERT_SVH
`define HEX_RECORD_DATA_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked on clk_i outside of reset.
`define HRDE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside of reset.
`define HRDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/hrde_pkg.sv
// Types, constants and the nibble decoder of the HEX record extractor.
package hrde_pkg;

  typedef logic [9:0] hrde_pos_t;

  typedef struct packed {
    logic [31:0] record_address;
    logic [6:0]  word_index;
    logic [15:0] halfword;
    logic        last_word;
  } hrde_word_t;

  localparam logic [7:0]  COLON_CHAR      = 8'h3A;
  localparam logic [7:0]  DIGIT_ZERO_CHAR = 8'h30;
  localparam logic [7:0]  DIGIT_NINE_CHAR = 8'h39;
  localparam logic [7:0]  LETTER_OFFSET   = 8'd55;
  localparam logic [15:0] HIGH_ADDR_RESET = 16'h0800;

  // Character positions within a record, counted from the colon.
  localparam hrde_pos_t POS_COUNT_HI = 10'd1;
  localparam hrde_pos_t POS_COUNT_LO = 10'd2;
  localparam hrde_pos_t POS_ADDR_3   = 10'd3;
  localparam hrde_pos_t POS_ADDR_2   = 10'd4;
  localparam hrde_pos_t POS_ADDR_1   = 10'd5;
  localparam hrde_pos_t POS_ADDR_0   = 10'd6;
  localparam hrde_pos_t POS_UNUSED   = 10'd7;
  localparam hrde_pos_t POS_TYPE     = 10'd8;

  // Digit slot within a four-character data group.
  localparam logic [1:0] DIGIT_FIRST = 2'd0;
  localparam logic [1:0] DIGIT_LAST  = 2'd3;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] diff;
    begin
      if (c >= DIGIT_ZERO_CHAR && c <= DIGIT_NINE_CHAR) begin
        diff = c - DIGIT_ZERO_CHAR;
      end else begin
        diff = c - LETTER_OFFSET;
      end
      return diff[3:0];
    end
  endfunction

endpackage

FILE: design/hrde_char_if.sv
// Input channel carrying one ASCII character per word.
interface hrde_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

FILE: design/hrde_word_if.sv
// Output channel carrying one extracted halfword with its address and index.
interface hrde_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] record_address;
  logic [6:0]  word_index;
  logic [15:0] halfword;
  logic        last_word;

  modport source (output valid, output record_address, output word_index,
                  output halfword, output last_word, input ready);
  modport sink (input valid, input record_address, input word_index,
                input halfword, input last_word, output ready);
endinterface

FILE: design/hrde_cfg_if.sv
// Configuration write channel for the upper address register.
interface hrde_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] high_address;

  modport source (output valid, output high_address, input ready);
  modport sink (input valid, input high_address, output ready);
endinterface

FILE: design/hrde_in_reg.sv
// Input register stage that captures one character word.
module hrde_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrde_char_if.sink  char_i,
  input  logic       advance_i,
  output logic       vld_o,
  output logic [7:0] char_o
);
  logic       vld_q, vld_d;
  logic [7:0] char_q, char_d;
  logic       take;

  assign char_i.ready = !vld_q || advance_i;
  assign take         = char_i.valid && char_i.ready;

  always_comb begin
    vld_d  = vld_q;
    char_d = char_q;
    if (char_i.ready) begin
      vld_d = char_i.valid;
    end
    if (take) begin
      char_d = char_i.char_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign vld_o  = vld_q;
  assign char_o = char_q;
endmodule

FILE: design/hrde_parser.sv
// Record parser: per-character state update and halfword assembly.
module hrde_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         char_in_i,
  input  logic [15:0]        high_addr_i,
  output logic               res_vld_o,
  output hrde_pkg::hrde_word_t res_o
);
  import hrde_pkg::*;

  logic        in_record_q, in_record_d;
  hrde_pos_t   pos_q, pos_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] low_addr_q, low_addr_d;
  logic [11:0] acc_q, acc_d;
  logic [6:0]  cur_word_q, cur_word_d;

  logic [3:0]  nib;
  logic [6:0]  words;
  logic [7:0]  next_idx;
  logic [1:0]  digit;
  logic        last;

  assign nib      = nibble_of(char_in_i);
  assign words    = count_q[7:1];
  assign next_idx = {1'b0, cur_word_q} + 8'd1;
  assign last     = (next_idx == {1'b0, words});
  // Data characters start at position nine, so the slot is (pos - 1) mod 4.
  assign digit    = pos_q[1:0] - 2'd1;

  always_comb begin
    in_record_d = in_record_q;
    pos_d       = pos_q;
    count_d     = count_q;
    low_addr_d  = low_addr_q;
    acc_d       = acc_q;
    cur_word_d  = cur_word_q;
    res_vld_o   = 1'b0;

    res_o.record_address = {high_addr_i, low_addr_q};
    res_o.word_index     = cur_word_q;
    res_o.halfword       = {acc_q[3:0], nib, acc_q[11:8], acc_q[7:4]};
    res_o.last_word      = last;

    if (char_in_i == COLON_CHAR) begin
      in_record_d = 1'b1;
      pos_d       = POS_COUNT_HI;
      count_d     = '0;
      low_addr_d  = '0;
      acc_d       = '0;
      cur_word_d  = '0;
    end else if (in_record_q) begin
      pos_d = pos_q + 10'd1;
      case (pos_q) inside
        POS_COUNT_HI, POS_COUNT_LO: begin
          count_d = {count_q[3:0], nib};
        end
        POS_ADDR_3, POS_ADDR_2, POS_ADDR_1, POS_ADDR_0: begin
          low_addr_d = {low_addr_q[11:0], nib};
        end
        POS_UNUSED: begin
        end
        POS_TYPE: begin
          // Only records whose type ends in digit zero and that hold at least one halfword stay open.
          if (nib != 4'd0 || words == 7'd0) begin
            in_record_d = 1'b0;
          end
        end
        default: begin
          case (digit)
            DIGIT_FIRST: acc_d = {8'd0, nib};
            DIGIT_LAST: begin
              res_vld_o  = 1'b1;
              cur_word_d = next_idx[6:0];
              if (last || next_idx >= {1'b0, words}) begin
                in_record_d = 1'b0;
              end
            end
            default: acc_d = {acc_q[7:0], nib};
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_record_q <= 1'b0;
      pos_q       <= '0;
      count_q     <= '0;
      low_addr_q  <= '0;
      acc_q       <= '0;
      cur_word_q  <= '0;
    end else if (step_i) begin
      in_record_q <= in_record_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      low_addr_q  <= low_addr_d;
      acc_q       <= acc_d;
      cur_word_q  <= cur_word_d;
    end
  end

`include "hex_record_data_extractor_assert.svh"

  `HRDE_ASSERT_IMP(a_emit_in_record, res_vld_o, in_record_q && char_in_i != COLON_CHAR, "halfword emitted outside a record")
  `HRDE_ASSERT_IMP(a_pos_nonzero, in_record_q, pos_q != '0, "open record with position zero")
  `HRDE_ASSERT_NEXT(a_last_closes, step_i && res_vld_o && last, !in_record_q, "record stayed open after its last halfword")
endmodule

FILE: design/hrde_out_reg.sv
// Output register holding one result word until the receiver takes it.
module hrde_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 res_vld_i,
  input  hrde_pkg::hrde_word_t res_i,
  output logic                 advance_o,
  hrde_word_if.source          word_o
);
  import hrde_pkg::*;

  logic       vld_q, vld_d;
  hrde_word_t data_q, data_d;

  // The stage moves when it is empty or its word leaves this cycle.
  assign advance_o = !vld_q || word_o.ready;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    if (advance_o) begin
      vld_d = step_i && res_vld_i;
    end
    if (advance_o && step_i && res_vld_i) begin
      data_d = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign word_o.valid          = vld_q;
  assign word_o.record_address = data_q.record_address;
  assign word_o.word_index     = data_q.word_index;
  assign word_o.halfword       = data_q.halfword;
  assign word_o.last_word      = data_q.last_word;
endmodule

FILE: design/hex_record_data_extractor.sv
// Top level of the HEX record data extractor.
// Usage: feed the record text one ASCII character per word on char_i. A colon
// opens a record; count, low address and type characters follow, and each
// group of four data chars of a record whose type ends in 0 yields one word on
// word_o: the 32-bit address (upper half from the configuration register),
// the halfword index within the record, the little-endian halfword and a
// flag on the record's last halfword. Other characters yield nothing.
// cfg_i writes the upper address register; it is always ready and should be
// written only while no character is in flight.
// Path: the fourth data character of a group is held in the input register,
// the parser forms the halfword from it, and the result register loads that
// word, which then drives word_o.
// Throughput: one character per cycle; both stages move together whenever
// the result register is empty or being taken.
// Reset clears the parser to "outside a record", empties both stages and
// loads the upper address register with 0x0800.
// When the receiver stalls, the result word holds, the character in the input
// register waits, and char_i stays ready until that register is occupied.
module hex_record_data_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrde_cfg_if.sink    cfg_i,
  hrde_char_if.sink   char_i,
  hrde_word_if.source word_o
);
  import hrde_pkg::*;

  logic [15:0] high_addr_q, high_addr_d;
  logic        advance;
  logic        in_vld;
  logic [7:0]  in_char;
  logic        step;
  logic        res_vld;
  hrde_word_t  res;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    high_addr_d = high_addr_q;
    if (cfg_i.valid) begin
      high_addr_d = cfg_i.high_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_addr_q <= HIGH_ADDR_RESET;
    end else begin
      high_addr_q <= high_addr_d;
    end
  end

  assign step = in_vld && advance;

  hrde_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_i    (char_i),
    .advance_i (advance),
    .vld_o     (in_vld),
    .char_o    (in_char)
  );

  hrde_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_in_i   (in_char),
    .high_addr_i (high_addr_q),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  hrde_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .res_vld_i (res_vld),
    .res_i     (res),
    .advance_o (advance),
    .word_o    (word_o)
  );
endmodule
